>>> hdl/assert_macros.svh
// Assertion macros shared by the upsampler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

>>> hdl/lip_pkg.sv
// Shared widths, codes and clamp function of the linear interpolation upsampler.
package lip_pkg;

	localparam int S_W       = 6;
	localparam int FMT_W     = 2;
	localparam int SMP_W     = 24;
	localparam int CH_W      = 3;
	localparam int DIFF_W    = 25;
	localparam int DIVD_W    = 24;
	localparam int Q_W       = 27;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DW    = 6;

	localparam logic [FMT_W-1:0] FMT_U8  = 2'd0;
	localparam logic [FMT_W-1:0] FMT_S16 = 2'd1;
	localparam logic [FMT_W-1:0] FMT_S24 = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 1'b1;

	localparam logic [S_W-1:0]   SCALE_RST = 6'd2;
	localparam logic [FMT_W-1:0] FMT_RST   = FMT_S16;

	localparam logic signed [Q_W-1:0] U8_LO  = 27'sd0;
	localparam logic signed [Q_W-1:0] U8_HI  = 27'sd255;
	localparam logic signed [Q_W-1:0] S16_LO = -27'sd32768;
	localparam logic signed [Q_W-1:0] S16_HI = 27'sd32767;
	localparam logic signed [Q_W-1:0] S24_LO = -27'sd8388608;
	localparam logic signed [Q_W-1:0] S24_HI = 27'sd8388607;

	// Clamp an interpolated point to the range of the sample format.
	function automatic logic signed [SMP_W-1:0] clamp_fmt(
		input logic signed [Q_W-1:0] v,
		input logic [FMT_W-1:0]      fmt
	);
		logic signed [Q_W-1:0] lo;
		logic signed [Q_W-1:0] hi;
		logic signed [Q_W-1:0] r;
		unique case (fmt)
			FMT_U8: begin
				lo = U8_LO;
				hi = U8_HI;
			end
			FMT_S16: begin
				lo = S16_LO;
				hi = S16_HI;
			end
			default: begin
				lo = S24_LO;
				hi = S24_HI;
			end
		endcase
		if (v < lo)
			r = lo;
		else if (v > hi)
			r = hi;
		else
			r = v;
		return r[SMP_W-1:0];
	endfunction

endpackage

>>> hdl/lip_div.sv
// Restoring serial divider: one quotient bit per cycle.
module lip_div import lip_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVD_W-1:0] dividend,
	input  logic [S_W-1:0]    divisor,
	output logic              done,
	output logic [DIVD_W-1:0] quotient,
	output logic [S_W-1:0]    remainder
);

	localparam int CNT_W = $clog2(DIVD_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIVD_W-1:0] quo_q;
	logic [S_W-1:0]    rem_q;
	logic [S_W-1:0]    dvs_q;

	logic [S_W:0] trial;
	logic [S_W:0] diff;
	logic         fits;

	assign trial = {rem_q, quo_q[DIVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift the dividend out and the quotient in.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVD_W-2:0], fits};
			rem_q <= fits ? diff[S_W-1:0] : trial[S_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

>>> hdl/linear_interp_upsampler.sv
// Top level of the integer-factor linear interpolation upsampler.
//
//  channel  | signals                                        | direction
//  ---------+------------------------------------------------+----------
//  input    | in_valid, in_ready, channel, sample, end_of_stream | into block
//  output   | out_valid, out_ready, out_channel, out_sample, last_of_run | out
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data      | into block
//
// A sample with a held predecessor is transferred, then the difference is
// formed and the serial divider started (difference / scale); once it is
// done the step is loaded and results follow one per cycle while the output
// is not stalled: scale results, or 2*scale on a final sample. A final
// sample with no predecessor gives scale results, one per cycle while the
// output is not stalled. Reset clears the per-channel history flags at once;
// no clearing pass. A stalled output holds the sequencer where it is.
`include "assert_macros.svh"
module linear_interp_upsampler import lip_pkg::*; #(
	parameter int MAX_CHANNELS = 8,
	parameter int MAX_SCALE    = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [CH_W-1:0]         channel,
	input  logic signed [SMP_W-1:0] sample,
	input  logic                    end_of_stream,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [CH_W-1:0]         out_channel,
	output logic signed [SMP_W-1:0] out_sample,
	output logic                    last_of_run,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DW-1:0]       cfg_data
);

	localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam logic [S_W-1:0] SCALE_MAX = S_W'(MAX_SCALE);

	// Sequencer states.
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DIV    = 3'd1;
	localparam logic [2:0] ST_A      = 3'd2;
	localparam logic [2:0] ST_INTERP = 3'd3;
	localparam logic [2:0] ST_B      = 3'd4;
	localparam logic [2:0] ST_ZERO   = 3'd5;

	logic [2:0]       state_q;
	logic [S_W-1:0]   scale_q;
	logic [FMT_W-1:0] fmt_q;

	// Per-channel history: the held sample and its flag.
	logic signed [SMP_W-1:0] prev_mem [MAX_CHANNELS];
	logic [MAX_CHANNELS-1:0] have_q;

	// Item being worked on.
	logic [CH_W-1:0]         ch_q;
	logic signed [SMP_W-1:0] a_q;
	logic signed [SMP_W-1:0] b_q;
	logic                    eos_q;
	logic [S_W-1:0]          s_q;
	logic [S_W-1:0]          k_q;
	logic                    dneg_q;
	logic                    div_go_q;

	// Running point n_k = q*s + r, and the per-step increment d = qd*s + rd.
	logic signed [Q_W-1:0] q_q;
	logic [S_W-1:0]        r_q;
	logic signed [Q_W-1:0] qd_q;
	logic [S_W-1:0]        rd_q;

	// Output register.
	logic                    out_valid_q;
	logic [CH_W-1:0]         out_ch_q;
	logic signed [SMP_W-1:0] out_smp_q;
	logic                    out_last_q;

	logic [S_W-1:0]           s_eff;
	logic                     in_fire;
	logic                     ch_ok;
	logic [IDX_W-1:0]         idx;
	logic signed [DIFF_W-1:0] d;
	logic                     d_neg;
	logic [DIFF_W-1:0]        d_mag;
	logic                     div_start;
	logic                     div_done;
	logic [DIVD_W-1:0]        div_quo;
	logic [S_W-1:0]           div_rem;
	logic signed [Q_W-1:0]    quo_ext;
	logic signed [Q_W-1:0]    qd_new;
	logic [S_W-1:0]           rd_new;

	logic                  emit_ok;
	logic                  emitting;
	logic                  pt_state;
	logic                  k_last;
	logic                  s_one;
	logic [S_W:0]          s_ext;
	logic [S_W:0]          r_sum;
	logic                  wrap;
	logic [S_W:0]          r_wrapped;
	logic [S_W-1:0]        r_next;
	logic signed [Q_W-1:0] q_next;
	logic                  inc;
	logic signed [Q_W-1:0] v_rnd;
	logic signed [SMP_W-1:0] e_smp;
	logic                  e_last;

	// Zero scale runs as one; anything above the build limit saturates.
	always_comb begin
		if (scale_q == '0)
			s_eff = S_W'(1);
		else if (scale_q > SCALE_MAX)
			s_eff = SCALE_MAX;
		else
			s_eff = scale_q;
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid && in_ready;
	assign ch_ok     = int'(channel) < MAX_CHANNELS;
	assign idx       = IDX_W'(channel);

	// Difference B - A from the latched item, split into sign and magnitude.
	assign d         = DIFF_W'(b_q) - DIFF_W'(a_q);
	assign d_neg     = d[DIFF_W-1];
	assign d_mag     = d_neg ? -d : d;
	assign div_start = div_go_q;

	lip_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (d_mag[DIVD_W-1:0]),
		.divisor   (s_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Turn the magnitude quotient into floor division of the signed difference.
	assign quo_ext = Q_W'(div_quo);
	always_comb begin
		if (dneg_q && (div_rem != '0)) begin
			qd_new = ~quo_ext;
			rd_new = s_q - div_rem;
		end else if (dneg_q) begin
			qd_new = -quo_ext;
			rd_new = div_rem;
		end else begin
			qd_new = quo_ext;
			rd_new = div_rem;
		end
	end

	// Advance the running point by d: add remainders, carry into the quotient.
	assign s_ext     = {1'b0, s_q};
	assign r_sum     = {1'b0, r_q} + {1'b0, rd_q};
	assign wrap      = r_sum >= s_ext;
	assign r_wrapped = wrap ? (r_sum - s_ext) : r_sum;
	assign r_next    = r_wrapped[S_W-1:0];
	assign q_next    = q_q + qd_q + $signed({{(Q_W-1){1'b0}}, wrap});

	// Round half away from zero: q is floor(n/s), sign of n is sign of q.
	assign inc   = q_q[Q_W-1] ? ({r_q, 1'b0} > s_ext) : ({r_q, 1'b0} >= s_ext);
	assign v_rnd = q_q + $signed({{(Q_W-1){1'b0}}, inc});

	assign s_one    = (s_q == S_W'(1));
	assign k_last   = (k_q == (s_q - S_W'(1)));
	assign pt_state = (state_q == ST_INTERP) || (state_q == ST_ZERO);
	assign emit_ok  = !out_valid_q || out_ready;
	assign emitting = emit_ok && ((state_q == ST_A) || (state_q == ST_INTERP) ||
		(state_q == ST_B) || (state_q == ST_ZERO));

	always_comb begin
		unique case (state_q)
			ST_A: begin
				e_smp  = a_q;
				e_last = s_one && !eos_q;
			end
			ST_INTERP: begin
				e_smp  = clamp_fmt(v_rnd, fmt_q);
				e_last = k_last && !eos_q;
			end
			ST_B: begin
				e_smp  = b_q;
				e_last = s_one;
			end
			ST_ZERO: begin
				e_smp  = '0;
				e_last = k_last;
			end
			default: begin
				e_smp  = '0;
				e_last = 1'b0;
			end
		endcase
	end

	// Control: configuration, sequencer, history flags, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scale_q     <= SCALE_RST;
			fmt_q       <= FMT_RST;
			have_q      <= '0;
			out_valid_q <= 1'b0;
			div_go_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_SCALE:  scale_q <= cfg_data[S_W-1:0];
					REG_FORMAT: fmt_q   <= cfg_data[FMT_W-1:0];
				endcase
			end

			// Start the divider once the held sample has been read.
			div_go_q <= in_fire && ch_ok && have_q[idx];

			if (emitting)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && ch_ok) begin
						have_q[idx] <= !end_of_stream;
						if (have_q[idx])
							state_q <= ST_DIV;
						else if (end_of_stream)
							state_q <= ST_B;
					end
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_A;
				end
				ST_A: begin
					if (emit_ok) begin
						if (!s_one)
							state_q <= ST_INTERP;
						else if (eos_q)
							state_q <= ST_B;
						else
							state_q <= ST_IDLE;
					end
				end
				ST_INTERP: begin
					if (emit_ok && k_last)
						state_q <= eos_q ? ST_B : ST_IDLE;
				end
				ST_B: begin
					if (emit_ok)
						state_q <= s_one ? ST_IDLE : ST_ZERO;
				end
				ST_ZERO: begin
					if (emit_ok && k_last)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath: latch the item, load the step, walk the points, fill output.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			ch_q  <= channel;
			b_q   <= sample;
			eos_q <= end_of_stream;
			s_q   <= s_eff;
			a_q   <= prev_mem[idx];
		end

		if (div_go_q)
			dneg_q <= d_neg;

		if (div_done) begin
			q_q  <= Q_W'(a_q);
			r_q  <= '0;
			qd_q <= qd_new;
			rd_q <= rd_new;
		end else if (emit_ok && ((state_q == ST_A) || (state_q == ST_INTERP))) begin
			q_q <= q_next;
			r_q <= r_next;
		end

		if (emit_ok) begin
			if ((state_q == ST_A) || (state_q == ST_B))
				k_q <= S_W'(1);
			else if (pt_state)
				k_q <= k_q + S_W'(1);
		end

		if (emitting) begin
			out_ch_q   <= ch_q;
			out_smp_q  <= e_smp;
			out_last_q <= e_last;
		end
	end

	// Hold the last sample of each open channel.
	always_ff @(posedge clk) begin
		if (in_fire && ch_ok && !end_of_stream)
			prev_mem[idx] <= sample;
	end

	assign out_valid   = out_valid_q;
	assign out_channel = out_ch_q;
	assign out_sample  = out_smp_q;
	assign last_of_run = out_last_q;

	`ASSERT_AT(a_rem_ok, clk, arst_n, (state_q == ST_INTERP) |-> (r_q < s_q), "remainder >= scale")
	`ASSERT_AT(a_k_ok, clk, arst_n, pt_state |-> (k_q != '0 && k_q < s_q), "bad point count")
	`ASSERT_NEVER(a_div_done_ok, clk, arst_n, div_done && (state_q != ST_DIV), "stray divider done")

endmodule

>>> tb/tb_linear_interp_upsampler.sv
// Self-checking testbench for the linear interpolation upsampler: directed and random PCM streams.
`timescale 1ns / 1ps

module tb_linear_interp_upsampler;
	import lip_pkg::*;

	localparam int NUM_CHANNELS = 8;
	localparam int SCALE_CAP    = 32;
	// Idle cycles after the last expected point before touching config or ending;
	// covers a first sample of a channel, which gives no output at all.
	localparam int SETTLE_CYCLES = 40;

	// One output point as the block should present it.
	typedef struct {
		logic [CH_W-1:0]         ch;
		logic signed [SMP_W-1:0] smp;
		logic                    last;
	} upsample_point_t;

	// Tracks per-channel history and the register file, expands every accepted
	// sample into the points it must produce, and checks the output stream.
	class pcm_upsample_scoreboard;
		logic [S_W-1:0]          scale_reg;
		logic [FMT_W-1:0]        format_reg;
		logic                    have_prev [NUM_CHANNELS];
		logic signed [SMP_W-1:0] prev_sample [NUM_CHANNELS];
		upsample_point_t         pending_points [$];
		int                      errors;

		function new();
			scale_reg  = 6'd2;
			format_reg = FMT_S16;
			errors     = 0;
			foreach (have_prev[i]) begin
				have_prev[i]   = 1'b0;
				prev_sample[i] = '0;
			end
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DW-1:0] data);
			if (idx == REG_SCALE)
				scale_reg = data[S_W-1:0];
			else
				format_reg = data[FMT_W-1:0];
		endfunction

		function int pending();
			return pending_points.size();
		endfunction

		// Zero counts as one, anything past the cap saturates.
		function longint points_per_sample();
			if (scale_reg == 0)
				return 1;
			if (scale_reg > SCALE_CAP)
				return SCALE_CAP;
			return longint'(scale_reg);
		endfunction

		function longint clamp_to_format(longint v);
			longint lo;
			longint hi;
			if (format_reg == FMT_U8) begin
				lo = 0;
				hi = 255;
			end else if (format_reg == FMT_S16) begin
				lo = -32768;
				hi = 32767;
			end else begin
				lo = -8388608;
				hi = 8388607;
			end
			if (v < lo)
				return lo;
			if (v > hi)
				return hi;
			return v;
		endfunction

		// n / s rounded half away from zero, s positive.
		function longint round_half_away(longint n, longint s);
			if (n >= 0)
				return (2 * n + s) / (2 * s);
			return -((-2 * n + s) / (2 * s));
		endfunction

		function void note_sample(logic [CH_W-1:0] ch, logic signed [SMP_W-1:0] smp,
				logic eos);
			upsample_point_t run [$];
			upsample_point_t pt;
			longint s;
			longint a;
			longint b;
			longint d;
			longint v;
			s = points_per_sample();
			b = smp;
			pt.ch   = ch;
			pt.last = 1'b0;
			if (have_prev[ch]) begin
				a = prev_sample[ch];
				d = b - a;
				// The held sample passes through unclamped.
				pt.smp = prev_sample[ch];
				run.push_back(pt);
				for (longint k = 1; k < s; k++) begin
					v = clamp_to_format(round_half_away(a * s + d * k, s));
					pt.smp = v[SMP_W-1:0];
					run.push_back(pt);
				end
			end
			if (eos) begin
				// Final sample: emit it, pad with zeros, and forget the channel.
				pt.smp = smp;
				run.push_back(pt);
				for (longint k = 1; k < s; k++) begin
					pt.smp = '0;
					run.push_back(pt);
				end
				have_prev[ch]   = 1'b0;
				prev_sample[ch] = '0;
			end else begin
				prev_sample[ch] = smp;
				have_prev[ch]   = 1'b1;
			end
			if (run.size() > 0)
				run[run.size() - 1].last = 1'b1;
			foreach (run[i])
				pending_points.push_back(run[i]);
		endfunction

		function void check_point(logic [CH_W-1:0] ch, logic signed [SMP_W-1:0] smp,
				logic last);
			upsample_point_t exp_pt;
			if (pending_points.size() == 0) begin
				$error("unexpected output point: out_channel %0d out_sample %0d last_of_run %b",
					ch, smp, last);
				errors++;
				return;
			end
			exp_pt = pending_points.pop_front();
			if (ch !== exp_pt.ch) begin
				$error("out_channel: expected %0d, actual %0d", exp_pt.ch, ch);
				errors++;
			end
			if (smp !== exp_pt.smp) begin
				$error("out_sample: expected %0d, actual %0d", exp_pt.smp, smp);
				errors++;
			end
			if (last !== exp_pt.last) begin
				$error("last_of_run: expected %b, actual %b", exp_pt.last, last);
				errors++;
			end
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [CH_W-1:0]         channel = '0;
	logic signed [SMP_W-1:0] sample = '0;
	logic                    end_of_stream = 1'b0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [CH_W-1:0]         out_channel;
	logic signed [SMP_W-1:0] out_sample;
	logic                    last_of_run;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DW-1:0]       cfg_data = '0;

	pcm_upsample_scoreboard sb = new();

	// Burst bookkeeping for the sender.
	int burst_left = 0;
	// Receiver stall pattern state.
	int rx_cycle = 0;
	int rx_mode = 0;

	linear_interp_upsampler u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.channel      (channel),
		.sample       (sample),
		.end_of_stream(end_of_stream),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_channel  (out_channel),
		.out_sample   (out_sample),
		.last_of_run  (last_of_run),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#12_000_000;
		$display("** linear_interp_upsampler: FAILED **");
		$finish;
	end

	// Receiver: periodically pick a stall style at random. Mode 0 never stalls,
	// mode 1 is a coin flip, mode 2 is ready three of five, mode 3 one of four.
	always @(posedge clk) begin
		rx_cycle++;
		if (rx_cycle % 150 == 0)
			rx_mode = $urandom_range(0, 3);
		case (rx_mode)
			0: begin
				out_ready <= 1'b1;
			end
			1: begin
				out_ready <= 1'($urandom_range(0, 1));
			end
			2: begin
				out_ready <= (rx_cycle % 5) < 3;
			end
			default: begin
				out_ready <= (rx_cycle % 4) == 0;
			end
		endcase
	end

	// Output monitor: every transfer on the output channel is checked in order.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_point(out_channel, out_sample, last_of_run);
	end

	// Present one sample and hold it until the transfer; the predictor learns
	// of it at the accepting edge.
	task automatic send_sample(logic [CH_W-1:0] ch, logic signed [SMP_W-1:0] smp, logic eos);
		in_valid      <= 1'b1;
		channel       <= ch;
		sample        <= smp;
		end_of_stream <= eos;
		do @(posedge clk); while (!in_ready);
		sb.note_sample(ch, smp, eos);
	endtask

	// Wait until every expected point has come out.
	task automatic drain_outputs();
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// Called between transfers: keep valid up inside a burst, otherwise drop it
	// for a random gap, or hold off until the output side has caught up.
	task automatic pace_sender(bit hold_for_drain);
		if (hold_for_drain) begin
			in_valid <= 1'b0;
			drain_outputs();
		end else if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(0, 20);
		end
	endtask

	// Write one register; caller guarantees the block is idle.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
	endtask

	task automatic configure(logic [S_W-1:0] scale_val, logic [FMT_W-1:0] fmt_val);
		logic [CFG_DW-1:0] fmt_word;
		// Upper bits of the format word are don't-care; toggle them anyway.
		fmt_word = {4'($urandom_range(0, 15)), fmt_val};
		write_reg(REG_SCALE, scale_val);
		write_reg(REG_FORMAT, fmt_word);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [SMP_W-1:0] pick_sample(logic [FMT_W-1:0] fmt);
		logic [31:0] raw;
		int r;
		raw = $urandom();
		r   = $urandom_range(0, 99);
		if (r < 12)
			return raw[SMP_W-1:0];
		if (r < 20) begin
			case ($urandom_range(0, 7))
				0: return 24'sd0;
				1: return -24'sd1;
				2: return 24'sd255;
				3: return 24'sd32767;
				4: return -24'sd32768;
				5: return 24'sd8388607;
				6: return -24'sd8388608;
				default: return 24'sd1;
			endcase
		end
		if (fmt == FMT_U8)
			return SMP_W'($urandom_range(0, 255));
		if (fmt == FMT_S16)
			return SMP_W'($urandom_range(0, 65535) - 32768);
		return raw[SMP_W-1:0];
	endfunction

	// Directed run under the reset configuration (scale 2, signed 16-bit).
	task automatic run_directed();
		// First sample stores only, then a ramp to full scale and a final sample
		// whose midpoint lands exactly on a half.
		send_sample(3'd0, 24'sd0, 1'b0);
		send_sample(3'd0, 24'sd32767, 1'b0);
		send_sample(3'd0, -24'sd32768, 1'b1);
		// Final sample with nothing held, far outside the 16-bit range.
		send_sample(3'd1, -24'sd8388608, 1'b1);
		// Out-of-range originals pass through; their midpoint is clamped.
		send_sample(3'd2, 24'sd8388607, 1'b0);
		send_sample(3'd2, 24'sd8388607, 1'b0);
		send_sample(3'd2, -24'sd8388608, 1'b0);
		send_sample(3'd2, 24'sd0, 1'b1);
		// Halves round away from zero in both directions.
		send_sample(3'd3, -24'sd1, 1'b0);
		send_sample(3'd3, 24'sd0, 1'b0);
		send_sample(3'd3, 24'sd1, 1'b0);
		send_sample(3'd3, -24'sd8388608, 1'b1);
		// Interleaved channels keep their own history.
		send_sample(3'd7, 24'sd5, 1'b0);
		send_sample(3'd6, -24'sd3, 1'b1);
		send_sample(3'd4, 24'sd100, 1'b0);
		send_sample(3'd7, -24'sd4, 1'b0);
		send_sample(3'd5, -24'sd32768, 1'b0);
		send_sample(3'd4, -24'sd101, 1'b0);
		send_sample(3'd7, -24'sd4, 1'b1);
		send_sample(3'd5, 24'sd32767, 1'b1);
		in_valid <= 1'b0;
	endtask

	// Mostly coherent per-channel streams with the occasional jump to another
	// channel and a final sample now and then.
	task automatic run_random(int count, bit force_drain);
		logic [CH_W-1:0] cur_ch;
		bit hold;
		cur_ch = CH_W'($urandom_range(0, NUM_CHANNELS - 1));
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) >= 60)
				cur_ch = CH_W'($urandom_range(0, NUM_CHANNELS - 1));
			send_sample(cur_ch, pick_sample(sb.format_reg), $urandom_range(0, 99) < 10);
			if (i == count - 1) begin
				in_valid <= 1'b0;
			end else begin
				hold = (force_drain && i == count / 2) || ($urandom_range(0, 49) == 0);
				pace_sender(hold);
			end
		end
	endtask

	initial begin
		int scale_plan [12] = '{1, 32, 3, 0, 63, 5, 17, 2, 33, 4, 7, 2};
		int fmt_plan [12]   = '{0, 2, 3, 1, 0, 2, 1, 3, 0, 1, 2, 1};
		// Hold reset, then release at a rising edge.
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		drain_outputs();
		repeat (SETTLE_CYCLES) @(posedge clk);

		// First random phase runs at the reset configuration.
		run_random($urandom_range(30, 40), 1'b1);
		drain_outputs();
		repeat (SETTLE_CYCLES) @(posedge clk);

		foreach (scale_plan[p]) begin
			configure(S_W'(scale_plan[p]), FMT_W'(fmt_plan[p]));
			run_random($urandom_range(30, 40), p == 3);
			drain_outputs();
			repeat (SETTLE_CYCLES) @(posedge clk);
		end

		if (sb.errors == 0 && sb.pending() == 0)
			$display("** linear_interp_upsampler: PASSED **");
		else
			$display("** linear_interp_upsampler: FAILED **");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+hdl
hdl/lip_pkg.sv
hdl/lip_div.sv
hdl/linear_interp_upsampler.sv
tb/tb_linear_interp_upsampler.sv
